>>> hw/rtl/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared widths, register indexes and pipeline control type for the box
// corner projection block.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int CoordW    = 24;
  localparam int PointW    = 25;
  localparam int CoefW     = 32;
  localparam int ProdW     = 57;
  localparam int DotW      = 58;
  localparam int NumW      = 59;
  localparam int RatioBits = 24;
  localparam int QW        = RatioBits + 2;
  localparam int ScrW      = 12;
  localparam int MulW      = ScrW + QW;
  localparam int PixW      = 16;
  localparam int PixLsb    = RatioBits - 3;
  localparam int CfgW      = 64;
  localparam int CfgIdxW   = 3;
  localparam int NumMatRegs = 6;
  localparam int NumRows   = 3;
  localparam int NumAxes   = 3;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 2;

  localparam logic [CfgIdxW-1:0] REG_ROW_X_LO = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW_X_HI = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW_Y_LO = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW_Y_HI = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW_W_LO = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROW_W_HI = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SCR_W    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SCR_H    = 3'd7;

  localparam logic [ScrW-1:0] SCR_W_RESET = 12'd1920;
  localparam logic [ScrW-1:0] SCR_H_RESET = 12'd1080;

  localparam logic signed [DotW-1:0] W_LIMIT = 58'sd1049;

  localparam logic [2:0] LAST_CORNER = 3'd7;

  typedef struct packed {
    logic v;
    logic first;
    logic last;
  } ctl_t;

endpackage

>>> hw/rtl/box_corner_projection.sv
// ----------------------------------------------------------------------------
// box_corner_projection
// Projects the 8 corners of an object box through a view matrix, one corner
// per cycle, and returns the screen bounding box with a visibility flag.
// ----------------------------------------------------------------------------
// A new item can be accepted as soon as the previous one sequences its last corner,
// while that one is still in the pipeline; the 8 corners share one pipelined
// projector (9 multipliers, ratio divider, screen multiplier). busy is high
// after each accepted item until its last corner is sequenced.
// Reset: synchronous, active low; clears the pipeline and loads register
// defaults (matrix 0, screen 1920 x 1080). The receiver cannot stall.
module box_corner_projection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_origin_x,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_origin_y,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_origin_z,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_min_x,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_min_y,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_min_z,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_max_x,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_max_y,
  input  logic signed [bcp_pkg::CoordW-1:0]   in_max_z,
  input  logic                                cfg_we,
  input  logic [bcp_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [bcp_pkg::CfgW-1:0]            cfg_wdata,
  output logic                                out_strobe,
  output logic                                out_visible,
  output logic [bcp_pkg::PixW-1:0]            out_left,
  output logic [bcp_pkg::PixW-1:0]            out_top,
  output logic [bcp_pkg::PixW-1:0]            out_box_width,
  output logic [bcp_pkg::PixW-1:0]            out_box_height
);
  import bcp_pkg::*;

  // configuration
  logic [CfgW-1:0]          mat_r [NumMatRegs];
  logic [ScrW-1:0]          scr_w_r;
  logic [ScrW-1:0]          scr_h_r;
  logic signed [CoefW-1:0]  coef [NumRows][4];

  // item front
  logic signed [CoordW-1:0] org [NumAxes];
  logic signed [CoordW-1:0] mn  [NumAxes];
  logic signed [CoordW-1:0] mx  [NumAxes];
  logic signed [PointW-1:0] lo_r [NumAxes];
  logic signed [PointW-1:0] hi_r [NumAxes];
  logic                     act_r;
  logic [2:0]               cnt_r;
  logic                     take;

  // corner stage
  ctl_t                     c_ctl_r;
  logic signed [PointW-1:0] c_p_r [NumAxes];

  // products
  ctl_t                     m_ctl_r;
  logic signed [ProdW-1:0]  m_prod_r [NumRows][NumAxes];
  logic signed [ProdW-1:0]  m_prod_nxt [NumRows][NumAxes];

  // partial sums
  ctl_t                     a_ctl_r;
  logic signed [DotW-1:0]   a_s01_r [NumRows];
  logic signed [DotW-1:0]   a_s2t_r [NumRows];

  // dot products
  ctl_t                     s_ctl_r;
  logic signed [DotW-1:0]   s_dot_r [NumRows];

  // numerators
  ctl_t                     n_ctl_r;
  logic signed [NumW-1:0]   n_num_r [2];
  logic signed [DotW-1:0]   n_w_r;
  logic                     n_low_r;

  // range check
  ctl_t                     d_ctl_r;
  logic                     d_ok_r;
  logic signed [NumW-1:0]   d_num_r [2];
  logic signed [NumW-1:0]   d_dif_r [2];
  logic signed [DotW-1:0]   d_w_r;
  logic signed [NumW-1:0]   d_w2;
  logic signed [NumW-1:0]   d_wx;

  // ratio divider
  ctl_t                     dv_ctl_r [RatioBits+1];
  logic                     dv_ok_r  [RatioBits+1];
  logic [DotW-1:0]          dv_w_r   [RatioBits+1];
  logic [DotW-1:0]          dv_rem_r [RatioBits+1][2];
  logic [QW-1:0]            dv_q_r   [RatioBits+1][2];
  logic [DotW-1:0]          dv_rem_nxt [RatioBits+1][2];
  logic [QW-1:0]            dv_q_nxt   [RatioBits+1][2];
  logic signed [NumW-1:0]   q0_sub;
  logic [NumW-1:0]          st_sh;
  logic [NumW-1:0]          st_dif;
  logic                     st_ge;

  // screen scale
  ctl_t                     mu_ctl_r;
  logic                     mu_ok_r;
  logic [MulW-1:0]          mu_x_r;
  logic [MulW-1:0]          mu_y_r;
  logic [PixW-1:0]          sx;
  logic [PixW-1:0]          sy;

  // bounding box
  logic                     acc_done_r;
  logic                     acc_ok_r;
  logic [PixW-1:0]          acc_l_r;
  logic [PixW-1:0]          acc_rt_r;
  logic [PixW-1:0]          acc_t_r;
  logic [PixW-1:0]          acc_b_r;

  // result
  logic                     out_strobe_r;
  logic                     out_visible_r;
  logic [PixW-1:0]          out_left_r;
  logic [PixW-1:0]          out_top_r;
  logic [PixW-1:0]          out_w_r;
  logic [PixW-1:0]          out_h_r;

  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumMatRegs; i++) begin
        mat_r[i] <= '0;
      end
      scr_w_r <= SCR_W_RESET;
      scr_h_r <= SCR_H_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_X_LO: mat_r[0] <= cfg_wdata;
        REG_ROW_X_HI: mat_r[1] <= cfg_wdata;
        REG_ROW_Y_LO: mat_r[2] <= cfg_wdata;
        REG_ROW_Y_HI: mat_r[3] <= cfg_wdata;
        REG_ROW_W_LO: mat_r[4] <= cfg_wdata;
        REG_ROW_W_HI: mat_r[5] <= cfg_wdata;
        REG_SCR_W:    scr_w_r  <= cfg_wdata[ScrW-1:0];
        REG_SCR_H:    scr_h_r  <= cfg_wdata[ScrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      coef[r][0] = mat_r[2*r][CoefW-1:0];
      coef[r][1] = mat_r[2*r][CfgW-1:CoefW];
      coef[r][2] = mat_r[2*r+1][CoefW-1:0];
      coef[r][3] = mat_r[2*r+1][CfgW-1:CoefW];
    end
  end

  // -------------------------------------------------------------------------
  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign mn[0]  = in_min_x;
  assign mn[1]  = in_min_y;
  assign mn[2]  = in_min_z;
  assign mx[0]  = in_max_x;
  assign mx[1]  = in_max_y;
  assign mx[2]  = in_max_z;

  assign busy = act_r && (cnt_r != LAST_CORNER);
  assign take = start && !busy;

  // control: valid bits and corner sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      cnt_r      <= '0;
      c_ctl_r    <= '0;
      m_ctl_r    <= '0;
      a_ctl_r    <= '0;
      s_ctl_r    <= '0;
      n_ctl_r    <= '0;
      d_ctl_r    <= '0;
      for (int s = 0; s <= RatioBits; s++) begin
        dv_ctl_r[s] <= '0;
      end
      mu_ctl_r     <= '0;
      acc_done_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (take) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        if (cnt_r == LAST_CORNER) begin
          act_r <= 1'b0;
        end
        cnt_r <= cnt_r + 3'd1;
      end
      c_ctl_r.v     <= act_r;
      c_ctl_r.first <= (cnt_r == 3'd0);
      c_ctl_r.last  <= (cnt_r == LAST_CORNER);
      m_ctl_r     <= c_ctl_r;
      a_ctl_r     <= m_ctl_r;
      s_ctl_r     <= a_ctl_r;
      n_ctl_r     <= s_ctl_r;
      d_ctl_r     <= n_ctl_r;
      dv_ctl_r[0] <= d_ctl_r;
      for (int s = 1; s <= RatioBits; s++) begin
        dv_ctl_r[s] <= dv_ctl_r[s-1];
      end
      mu_ctl_r     <= dv_ctl_r[RatioBits];
      acc_done_r   <= mu_ctl_r.v && mu_ctl_r.last;
      out_strobe_r <= acc_done_r;
    end
  end

  // -------------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < NumAxes; k++) begin
        m_prod_nxt[r][k] = ProdW'(coef[r][k]) * ProdW'(c_p_r[k]);
      end
    end
  end

  assign d_w2 = NumW'(n_w_r) <<< 1;
  assign d_wx = NumW'(d_w_r);

  // first quotient digit (0, 1 or 2) and the fractional steps
  always_comb begin
    q0_sub = '0;
    st_sh  = '0;
    st_dif = '0;
    st_ge  = 1'b0;
    for (int ax = 0; ax < 2; ax++) begin
      dv_rem_nxt[0][ax] = d_num_r[ax][DotW-1:0];
      dv_q_nxt[0][ax]   = '0;
      q0_sub = d_dif_r[ax] - d_wx;
      if (!d_dif_r[ax][NumW-1]) begin
        if (!q0_sub[NumW-1]) begin
          dv_rem_nxt[0][ax] = q0_sub[DotW-1:0];
          dv_q_nxt[0][ax]   = QW'(2);
        end else begin
          dv_rem_nxt[0][ax] = d_dif_r[ax][DotW-1:0];
          dv_q_nxt[0][ax]   = QW'(1);
        end
      end
    end
    for (int s = 1; s <= RatioBits; s++) begin
      for (int ax = 0; ax < 2; ax++) begin
        st_sh  = {dv_rem_r[s-1][ax], 1'b0};
        st_ge  = (st_sh >= {1'b0, dv_w_r[s-1]});
        st_dif = st_sh - {1'b0, dv_w_r[s-1]};
        dv_rem_nxt[s][ax] = st_ge ? st_dif[DotW-1:0] : st_sh[DotW-1:0];
        dv_q_nxt[s][ax]   = {dv_q_r[s-1][ax][QW-2:0], st_ge};
      end
    end
  end

  assign sx = mu_x_r[PixLsb+PixW-1:PixLsb];
  assign sy = mu_y_r[PixLsb+PixW-1:PixLsb];

  // datapath
  always_ff @(posedge clk) begin
    if (take) begin
      for (int a = 0; a < NumAxes; a++) begin
        lo_r[a] <= PointW'(org[a]) + PointW'(mn[a]);
        hi_r[a] <= PointW'(org[a]) + PointW'(mx[a]);
      end
    end

    for (int a = 0; a < NumAxes; a++) begin
      c_p_r[a] <= cnt_r[a] ? hi_r[a] : lo_r[a];
    end

    m_prod_r <= m_prod_nxt;

    for (int r = 0; r < NumRows; r++) begin
      a_s01_r[r] <= DotW'(m_prod_r[r][0]) + DotW'(m_prod_r[r][1]);
      a_s2t_r[r] <= DotW'(m_prod_r[r][2]) + (DotW'(coef[r][3]) <<< 4);
      s_dot_r[r] <= a_s01_r[r] + a_s2t_r[r];
    end

    n_num_r[0] <= NumW'(s_dot_r[ROW_W]) + NumW'(s_dot_r[ROW_X]);
    n_num_r[1] <= NumW'(s_dot_r[ROW_W]) - NumW'(s_dot_r[ROW_Y]);
    n_w_r      <= s_dot_r[ROW_W];
    n_low_r    <= (s_dot_r[ROW_W] < W_LIMIT);

    d_ok_r <= !n_low_r && !n_num_r[0][NumW-1] && !n_num_r[1][NumW-1]
              && (n_num_r[0] <= d_w2) && (n_num_r[1] <= d_w2);
    for (int ax = 0; ax < 2; ax++) begin
      d_num_r[ax] <= n_num_r[ax];
      d_dif_r[ax] <= n_num_r[ax] - NumW'(n_w_r);
    end
    d_w_r <= n_w_r;

    dv_ok_r[0] <= d_ok_r;
    dv_w_r[0]  <= d_w_r[DotW-1:0];
    for (int s = 1; s <= RatioBits; s++) begin
      dv_ok_r[s] <= dv_ok_r[s-1];
      dv_w_r[s]  <= dv_w_r[s-1];
    end
    dv_rem_r <= dv_rem_nxt;
    dv_q_r   <= dv_q_nxt;

    mu_ok_r <= dv_ok_r[RatioBits];
    mu_x_r  <= MulW'(scr_w_r) * MulW'(dv_q_r[RatioBits][0]);
    mu_y_r  <= MulW'(scr_h_r) * MulW'(dv_q_r[RatioBits][1]);

    if (mu_ctl_r.v) begin
      if (mu_ctl_r.first) begin
        acc_ok_r <= mu_ok_r;
        acc_l_r  <= sx;
        acc_rt_r <= sx;
        acc_t_r  <= sy;
        acc_b_r  <= sy;
      end else begin
        acc_ok_r <= acc_ok_r && mu_ok_r;
        if (sx < acc_l_r) acc_l_r <= sx;
        if (sx > acc_rt_r) acc_rt_r <= sx;
        if (sy < acc_t_r) acc_t_r <= sy;
        if (sy > acc_b_r) acc_b_r <= sy;
      end
    end

    if (acc_done_r) begin
      out_visible_r <= acc_ok_r;
      out_left_r    <= acc_ok_r ? acc_l_r : '0;
      out_top_r     <= acc_ok_r ? acc_t_r : '0;
      out_w_r       <= acc_ok_r ? (acc_rt_r - acc_l_r) : '0;
      out_h_r       <= acc_ok_r ? (acc_b_r - acc_t_r) : '0;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_visible    = out_visible_r;
  assign out_left       = out_left_r;
  assign out_top        = out_top_r;
  assign out_box_width  = out_w_r;
  assign out_box_height = out_h_r;

endmodule
